// File: rtl/core/threshold_peak_hit_detector_assert.svh
// Assertion macros used by the threshold peak hit detector checker.
`ifndef THRESHOLD_PEAK_HIT_DETECTOR_ASSERT_SVH
`define THRESHOLD_PEAK_HIT_DETECTOR_ASSERT_SVH

// Clocked property, switched off while reset is high.
`define TPD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds across reset.
`define TPD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/tpd_pkg.sv
// Types and constants of the threshold peak hit detector.
package tpd_pkg;

   localparam int unsigned SampleWidth = 24;
   localparam int unsigned LevelWidth  = 23;
   localparam int unsigned CountWidth  = 32;
   localparam int unsigned SmallWidth  = 4;
   localparam int unsigned CsrIdxWidth = 2;

   // Search phases
   localparam logic [1:0] PH_IDLE      = 2'd0;
   localparam logic [1:0] PH_FIRST     = 2'd1;
   localparam logic [1:0] PH_SEARCH    = 2'd2;
   localparam logic [1:0] PH_WAIT_ZERO = 2'd3;

   // Register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_TRIGGER_LEVEL = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_RISE_MARGIN   = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_HOLDOFF_PEAKS = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_FALLS_TO_END  = 2'd3;

   localparam logic [LevelWidth-1:0] TRIGGER_LEVEL_RST = 23'd335544;
   localparam logic [LevelWidth-1:0] RISE_MARGIN_RST   = 23'd201327;
   localparam logic [SmallWidth-1:0] HOLDOFF_PEAKS_RST = 4'd2;
   localparam logic [SmallWidth-1:0] FALLS_TO_END_RST  = 4'd2;

   typedef struct packed {
      logic [LevelWidth-1:0] trigger_level;
      logic [LevelWidth-1:0] rise_margin;
      logic [SmallWidth-1:0] holdoff_peaks;
      logic [SmallWidth-1:0] falls_to_end;
   } cfg_type;

   typedef struct packed {
      logic                          is_hit;
      logic                          is_follow_up;
      logic signed [SampleWidth-1:0] peak_value;
      logic [CountWidth-1:0]         peak_index;
      logic [CountWidth-1:0]         end_index;
   } result_type;

endpackage

// File: rtl/core/tpd_peak_core.sv
// Peak search state and per-sample decision logic.
module tpd_peak_core import tpd_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic signed [SampleWidth-1:0] sample,
   input  cfg_type                       cfg,
   output logic                          res_valid,
   output result_type                    res
);

   logic [1:0]                    phase_ff, phase_in;
   logic [SmallWidth-1:0]         fall_ff, fall_in;
   logic signed [SampleWidth-1:0] max_ff, max_in;
   logic [CountWidth-1:0]         rise_ff, rise_in;
   logic signed [SampleWidth-1:0] prev_ff, prev_in;
   logic [SmallWidth-1:0]         hold_ff, hold_in;
   logic [CountWidth-1:0]         count_ff, count_in;

   logic                  above_trigger;
   logic                  at_or_below_zero;
   logic [SmallWidth-1:0] fall_next;
   logic [SmallWidth-1:0] fall_limit;
   logic                  follow;
   logic [SmallWidth-1:0] hold_dec;
   logic signed [SampleWidth+1:0] max_wide;
   logic signed [SampleWidth+1:0] bar_wide;
   logic                  hit;

   assign count_in         = count_ff + 1'b1;
   assign above_trigger    = $signed({sample[SampleWidth-1], sample})
                             > $signed({2'b00, cfg.trigger_level});
   assign at_or_below_zero = sample[SampleWidth-1] || (sample == '0);
   assign fall_next        = fall_ff + 1'b1;
   assign fall_limit       = (cfg.falls_to_end == '0) ? SmallWidth'(1) : cfg.falls_to_end;
   assign follow           = (hold_ff != '0);
   assign hold_dec         = follow ? (hold_ff - 1'b1) : hold_ff;
   assign max_wide         = $signed({{2{max_ff[SampleWidth-1]}}, max_ff});
   assign bar_wide         = $signed({{2{prev_ff[SampleWidth-1]}}, prev_ff})
                             + $signed({3'b000, cfg.rise_margin});
   assign hit              = (hold_dec == '0) && (max_wide > bar_wide);

   always_comb begin
      phase_in  = phase_ff;
      fall_in   = fall_ff;
      max_in    = max_ff;
      rise_in   = rise_ff;
      prev_in   = prev_ff;
      hold_in   = hold_ff;
      res_valid = 1'b0;
      res.is_hit       = hit;
      res.is_follow_up = follow;
      res.peak_value   = max_ff;
      res.peak_index   = rise_ff;
      res.end_index    = count_in;
      case (phase_ff)
         PH_IDLE: begin
            if (above_trigger) phase_in = PH_FIRST;
         end
         PH_FIRST: begin
            max_in   = sample;
            fall_in  = '0;
            phase_in = PH_SEARCH;
         end
         PH_WAIT_ZERO: begin
            if (at_or_below_zero) phase_in = PH_IDLE;
         end
         PH_SEARCH: begin
            if (sample > max_ff) begin
               max_in  = sample;
               rise_in = count_in;
               fall_in = '0;
            end else if (fall_next < fall_limit) begin
               fall_in = fall_next;
            end else begin
               // peak finished: settle hold-off, record it, report one beat
               hold_in   = hit ? cfg.holdoff_peaks : hold_dec;
               prev_in   = max_ff;
               phase_in  = PH_WAIT_ZERO;
               fall_in   = '0;
               res_valid = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         fall_ff  <= '0;
         max_ff   <= '0;
         rise_ff  <= '0;
         prev_ff  <= '0;
         hold_ff  <= '0;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         fall_ff  <= fall_in;
         max_ff   <= max_in;
         rise_ff  <= rise_in;
         prev_ff  <= prev_in;
         hold_ff  <= hold_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/core/threshold_peak_hit_detector.sv
// Top level of the threshold peak hit detector.
//
// Samples enter on the req_ channel (valid/ready), one 24-bit two's
// complement code per beat. A result beat leaves on the rsp_ channel only
// when a peak search ends; most samples produce no result.
// Registers are written through the csr_ port (write enable, index, data);
// the user must write them only while the block is idle, which the block
// does not enforce; they take effect on the next sample. A result is
// registered by the clock edge that accepts the sample ending its peak.
// Throughput: one sample per cycle while no result is stalled; every sample
// is decided by one pass of compare and count logic between the state
// registers and the result register.
// A stalled receiver holds the result register; a new sample is taken in
// the same cycle the held result is taken, and none while it waits.
// Reset (synchronous) returns the search to idle, clears the sample count,
// the previous peak and the hold-off, and loads register defaults.
module threshold_peak_hit_detector import tpd_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SampleWidth-1:0] req_sample_code,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_is_hit,
   output logic                          rsp_is_follow_up,
   output logic signed [SampleWidth-1:0] rsp_peak_value,
   output logic [CountWidth-1:0]         rsp_peak_index,
   output logic [CountWidth-1:0]         rsp_end_index,
   input  logic                          csr_wr_en,
   input  logic [CsrIdxWidth-1:0]        csr_index,
   input  logic [LevelWidth-1:0]         csr_wdata
);

   cfg_type    cfg_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   logic       accept;
   logic       res_valid;
   result_type res;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_level <= TRIGGER_LEVEL_RST;
         cfg_ff.rise_margin   <= RISE_MARGIN_RST;
         cfg_ff.holdoff_peaks <= HOLDOFF_PEAKS_RST;
         cfg_ff.falls_to_end  <= FALLS_TO_END_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TRIGGER_LEVEL: cfg_ff.trigger_level <= csr_wdata;
            CSR_RISE_MARGIN:   cfg_ff.rise_margin   <= csr_wdata;
            CSR_HOLDOFF_PEAKS: cfg_ff.holdoff_peaks <= csr_wdata[SmallWidth-1:0];
            CSR_FALLS_TO_END:  cfg_ff.falls_to_end  <= csr_wdata[SmallWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   tpd_peak_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .sample    (req_sample_code),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // drop the held beat when taken; load a new one only on an accepted sample
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= accept && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_hit       = rsp_ff.is_hit;
   assign rsp_is_follow_up = rsp_ff.is_follow_up;
   assign rsp_peak_value   = rsp_ff.peak_value;
   assign rsp_peak_index   = rsp_ff.peak_index;
   assign rsp_end_index    = rsp_ff.end_index;

endmodule

// File: rtl/core/tpd_checker.sv
// Port-level checker for the threshold peak hit detector, with its bind.
`include "threshold_peak_hit_detector_assert.svh"

module tpd_checker import tpd_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_is_hit,
   input logic                          rsp_is_follow_up,
   input logic signed [SampleWidth-1:0] rsp_peak_value,
   input logic [CountWidth-1:0]         rsp_peak_index,
   input logic [CountWidth-1:0]         rsp_end_index
);

   `TPD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_is_hit, rsp_is_follow_up, rsp_peak_value, rsp_peak_index, rsp_end_index}), "rsp beat changed while stalled")
   `TPD_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "rsp beat present after reset")
   `TPD_ASSERT(a_stall_blocks_req, clock, reset, rsp_valid && !rsp_ready |-> !req_ready, "sample taken while result stalled")
   `TPD_ASSERT(a_rsp_from_req, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready), "rsp beat without an accepted sample")

endmodule

bind threshold_peak_hit_detector tpd_checker u_tpd_checker (.*);

// File: tb/sv/tb.sv
// Self-checking testbench for the threshold peak hit detector.
module tb;
   import tpd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CodeMax = 8388607;
   localparam int CodeMin = -8388608;
   localparam int CmpWidth = CountWidth + 1;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [SampleWidth-1:0] req_sample_code = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_is_hit;
   logic                          rsp_is_follow_up;
   logic signed [SampleWidth-1:0] rsp_peak_value;
   logic [CountWidth-1:0]         rsp_peak_index;
   logic [CountWidth-1:0]         rsp_end_index;
   logic                          csr_wr_en = 1'b0;
   logic [CsrIdxWidth-1:0]        csr_index = '0;
   logic [LevelWidth-1:0]         csr_wdata = '0;

   // Shadow copy of the registers
   logic [LevelWidth-1:0] trig_lvl    = TRIGGER_LEVEL_RST;
   logic [LevelWidth-1:0] margin      = RISE_MARGIN_RST;
   logic [SmallWidth-1:0] holdoff_cfg = HOLDOFF_PEAKS_RST;
   logic [SmallWidth-1:0] falls_cfg   = FALLS_TO_END_RST;

   // Peak search state as the block should hold it
   logic [1:0]                    srch_phase  = PH_IDLE;
   logic [SmallWidth-1:0]         fall_run    = '0;
   logic signed [SampleWidth-1:0] run_max     = '0;
   logic [CountWidth-1:0]         rise_cnt    = '0;
   logic signed [SampleWidth-1:0] last_peak   = '0;
   logic [SmallWidth-1:0]         holdoff_cnt = '0;
   logic [CountWidth-1:0]         sample_cnt  = '0;

   result_type peaks_due[$];

   bit steady = 1'b0;
   int mismatches = 0;
   int samples_sent = 0;
   int peaks_checked = 0;
   int hits_seen = 0;
   int follow_ups_seen = 0;
   int settings_used = 0;

   threshold_peak_hit_detector uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_code  (req_sample_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_is_hit       (rsp_is_hit),
      .rsp_is_follow_up (rsp_is_follow_up),
      .rsp_peak_value   (rsp_peak_value),
      .rsp_peak_index   (rsp_peak_index),
      .rsp_end_index    (rsp_end_index),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int rand_span(input int lo, input int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   // Advance the expected search state by one sample; queue a peak report when one ends.
   function automatic void predict_peak(input logic signed [SampleWidth-1:0] s);
      result_type            r;
      logic [SmallWidth-1:0] lim;
      sample_cnt = sample_cnt + 1'b1;
      case (srch_phase)
         PH_IDLE: begin
            if (int'(s) > int'(trig_lvl)) srch_phase = PH_FIRST;
         end
         PH_FIRST: begin
            run_max = s;
            fall_run = '0;
            srch_phase = PH_SEARCH;
         end
         PH_WAIT_ZERO: begin
            if (s <= 0) srch_phase = PH_IDLE;
         end
         PH_SEARCH: begin
            if (s > run_max) begin
               run_max = s;
               rise_cnt = sample_cnt;
               fall_run = '0;
            end else begin
               fall_run = fall_run + 1'b1;
               lim = (falls_cfg == '0) ? SmallWidth'(1) : falls_cfg;
               if (fall_run >= lim) begin
                  r.is_follow_up = (holdoff_cnt != '0);
                  if (r.is_follow_up) holdoff_cnt = holdoff_cnt - 1'b1;
                  r.is_hit = (holdoff_cnt == '0) &&
                             (int'(run_max) > int'(last_peak) + int'(margin));
                  if (r.is_hit) holdoff_cnt = holdoff_cfg;
                  r.peak_value = run_max;
                  r.peak_index = rise_cnt;
                  r.end_index  = sample_cnt;
                  last_peak = run_max;
                  srch_phase = PH_WAIT_ZERO;
                  fall_run = '0;
                  peaks_due.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) predict_peak(req_sample_code);
   end

   always @(posedge clock) begin
      if (reset || steady) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(99) >= 29);
   end

   function automatic void compare_field(input string name,
                                         input logic signed [CountWidth:0] want,
                                         input logic signed [CountWidth:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : peak_check
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (peaks_due.size() == 0) begin
            mismatches++;
            $display("%0t: peak report with none expected, expected nothing got end_index %0d",
                     $time, rsp_end_index);
         end else begin
            want = peaks_due.pop_front();
            compare_field("is_hit", CmpWidth'(want.is_hit), CmpWidth'(rsp_is_hit));
            compare_field("is_follow_up", CmpWidth'(want.is_follow_up),
                          CmpWidth'(rsp_is_follow_up));
            compare_field("peak_value", CmpWidth'(want.peak_value), CmpWidth'(rsp_peak_value));
            compare_field("peak_index", CmpWidth'(want.peak_index), CmpWidth'(rsp_peak_index));
            compare_field("end_index", CmpWidth'(want.end_index), CmpWidth'(rsp_end_index));
            peaks_checked++;
            if (want.is_hit) hits_seen++;
            if (want.is_follow_up) follow_ups_seen++;
         end
      end
   end

   // Hold the sample until its beat is taken; valid stays high for a back-to-back call.
   task automatic send_sample(input int code);
      int gap;
      gap = 0;
      if (!steady) while ($urandom_range(99) < 29) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_code <= code[SampleWidth-1:0];
      do @(posedge clock); while (!req_ready);
      samples_sent++;
   endtask

   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx, input int unsigned val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= LevelWidth'(val);
      @(posedge clock);
   endtask

   task automatic load_settings(input int unsigned tl, input int unsigned rm,
                                input int unsigned hp, input int unsigned fe);
      write_reg(CSR_TRIGGER_LEVEL, tl);
      write_reg(CSR_RISE_MARGIN, rm);
      write_reg(CSR_HOLDOFF_PEAKS, hp);
      write_reg(CSR_FALLS_TO_END, fe);
      csr_wr_en <= 1'b0;
      trig_lvl    = LevelWidth'(tl);
      margin      = LevelWidth'(rm);
      holdoff_cfg = SmallWidth'(hp);
      falls_cfg   = SmallWidth'(fe);
      settings_used++;
   endtask

   // Drop valid, then wait out every pending report plus the result register.
   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (peaks_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_noise();
      repeat ($urandom_range(6, 1)) send_sample(rand_span(CodeMin, CodeMax));
   endtask

   // Trigger, first sample, rises, then (unless abandoned) enough non-rising samples, then a drop to or below zero.
   task automatic send_peak();
      int cur;
      int lim;
      int falls;
      int top;
      if (int'(trig_lvl) >= CodeMax) begin
         send_noise();
         return;
      end
      send_sample(rand_span(int'(trig_lvl) + 1, CodeMax));
      cur = ($urandom_range(3) == 0) ? rand_span(CodeMin, CodeMax) : rand_span(0, CodeMax);
      send_sample(cur);
      repeat ($urandom_range(4)) begin
         if (cur < CodeMax) begin
            top = (cur > CodeMax - 1048576) ? CodeMax : cur + 1048576;
            cur = rand_span(cur + 1, top);
            send_sample(cur);
         end
      end
      // abandon the search now and then
      if ($urandom_range(9) == 0) return;
      lim = (falls_cfg == '0) ? 1 : int'(falls_cfg);
      falls = 0;
      while (falls < lim) begin
         if (cur < CodeMax && $urandom_range(7) == 0) begin
            cur = rand_span(cur + 1, CodeMax);
            send_sample(cur);
            falls = 0;
         end else begin
            send_sample(($urandom_range(3) == 0) ? cur : rand_span(CodeMin, cur));
            falls++;
         end
      end
      repeat ($urandom_range(2)) send_sample(rand_span(1, CodeMax));
      send_sample(($urandom_range(3) == 0) ? 0 : rand_span(CodeMin, 0));
   endtask

   task automatic run_random_phase(input int target);
      int start;
      start = samples_sent;
      while (samples_sent - start < target) begin
         if ($urandom_range(4) == 0) send_noise();
         else send_peak();
      end
   endtask

   // Reset register values: threshold equality, a rise, a hit, a wait for zero.
   task automatic test_default_peak();
      send_sample(335544);
      send_sample(335545);
      send_sample(500000);
      send_sample(600000);
      send_sample(600000);
      send_sample(0);
      send_sample(1);
      send_sample(CodeMin);
      drain_block();
   endtask

   // Hold-off countdown, peaks without a rise, zero fall count, hit with follow-up.
   task automatic test_hold_off();
      load_settings(0, 0, 1, 0);
      send_sample(1);
      send_sample(CodeMax);
      send_sample(CodeMax);
      send_sample(0);
      send_sample(5);
      send_sample(CodeMin);
      send_sample(CodeMin);
      send_sample(-1);
      send_sample(7);
      send_sample(100);
      send_sample(200);
      send_sample(50);
      send_sample(0);
      send_sample(9);
      send_sample(300);
      send_sample(300);
      send_sample(0);
      drain_block();
   endtask

   // Largest register values: nothing can pass the trigger level.
   task automatic test_register_extremes();
      load_settings(CodeMax, CodeMax, 15, 15);
      send_sample(CodeMax);
      send_sample(-1);
      send_noise();
      drain_block();
   endtask

   task automatic test_random_stimulus();
      for (int k = 0; k < 8; k++) begin
         case (k)
            0: load_settings(0, 0, 0, 1);
            1: load_settings($urandom_range(1048576), CodeMax, 15, 15);
            2: load_settings(TRIGGER_LEVEL_RST, RISE_MARGIN_RST, HOLDOFF_PEAKS_RST,
                             FALLS_TO_END_RST);
            default: load_settings($urandom_range(4194304), $urandom_range(2097152),
                                   $urandom_range(15), $urandom_range(15));
         endcase
         // one phase runs with neither side pausing
         steady = (k == 2);
         run_random_phase(150);
         drain_block();
         steady = 1'b0;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_peak();
      test_hold_off();
      test_register_extremes();
      test_random_stimulus();
      $display("Sent %0d samples under %0d register settings plus reset values.",
               samples_sent, settings_used);
      $display("Checked %0d peak reports: %0d hits, %0d follow-ups.",
               peaks_checked, hits_seen, follow_ups_seen);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Timeout: %0d peak reports still pending", peaks_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/tpd_pkg.sv
rtl/core/tpd_peak_core.sv
rtl/core/threshold_peak_hit_detector.sv
rtl/core/tpd_checker.sv
tb/sv/tb.sv
